/* rtl/core/prrn_pkg.sv */
package prrn_pkg;

  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned CNT_W_DEF      = 9;

  // shared adder width: 32-bit distance plus 16-bit step with room for sign
  localparam int unsigned ACC_W = 34;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_REC  = 2'd1,
    CMD_PLAY = 2'd2,
    CMD_IDLE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_STORED  = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_ARRIVED = 3'd3,
    STAT_REFUSED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_CRUISE   = 2'd1,
    REG_RAMP     = 2'd2,
    REG_GAIN     = 2'd3
  } reg_idx_e;

  // register reset values
  localparam logic [15:0] INTERVAL_RST = 16'd100;
  localparam logic [14:0] CRUISE_RST   = 15'd100;
  localparam logic [7:0]  RAMP_RST     = 8'd2;
  localparam logic [8:0]  GAIN_RST     = 9'd26;
  localparam logic [8:0]  GAIN_ONE     = 9'd256;

  // angles in 1/64 degree, filter angles carry 8 more fraction bits
  localparam acc_t DEG180       = 34'sd11520;
  localparam acc_t NEG_DEG180   = -34'sd11520;
  localparam acc_t DEG360       = 34'sd23040;
  localparam acc_t ERR_HALF     = 34'sd2949120;
  localparam acc_t NEG_ERR_HALF = -34'sd2949120;
  localparam acc_t ERR_FULL     = 34'sd5898240;
  localparam acc_t SMOOTH_MAX   = 34'sd8388607;
  localparam acc_t SMOOTH_MIN   = -34'sd8388608;
  localparam acc_t SAT_MAX      = 34'sd2147483647;
  localparam acc_t SAT_MIN      = -34'sd2147483648;

  // largest drive speed: cruise limit minus one plus a full ramp step
  localparam logic [15:0] SPEED_MAX = 16'd33021;

endpackage

/* rtl/core/prrn_item_if.sv */
interface prrn_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] distance_step;
  logic signed [15:0] heading;

  modport source (output valid, cmd, distance_step, heading, input ready);
  modport sink (input valid, cmd, distance_step, heading, output ready);
endinterface

/* rtl/core/prrn_result_if.sv */
interface prrn_result_if #(
  parameter int unsigned CntW = prrn_pkg::CNT_W_DEF
);
  logic               valid;
  logic               ready;
  logic [15:0]        speed_out;
  logic signed [15:0] heading_out;
  logic [1:0]         mode;
  logic [CntW-1:0]    point_count;
  logic [2:0]         status;

  modport source (output valid, speed_out, heading_out, mode, point_count, status,
                  input ready);
  modport sink (input valid, speed_out, heading_out, mode, point_count, status,
                output ready);
endinterface

/* rtl/core/path_record_replay_navigator.sv */
// channel   | dir | beat content                                   | handshake
// ----------+-----+------------------------------------------------+-------------
// item_i    | in  | cmd, distance_step, heading                    | valid/ready
// result_o  | out | speed_out, heading_out, mode, point_count, status | valid/ready
// apb       | in  | record_interval, cruise_speed, ramp step, gain  | psel/penable
//
// one item at a time; how long an item takes depends on its kind and, in playback,
// grows with each waypoint passed; it is set by the single add/sub unit stepping
// the angle wraps and by the one read port of the waypoint memory
// rst_ni clears mode, counters, distances, speed, heading and the result valid flag;
// the waypoint memory is not cleared, only entries below the stored count are read
// a finished result waits in the output register, item_i is ready again meanwhile
module path_record_replay_navigator #(
  parameter int unsigned MAX_POINTS = prrn_pkg::MAX_POINTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  prrn_item_if.sink        item_i,
  prrn_result_if.source    result_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  // sequencer states, one-hot
  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_CMD   = 16'b0000_0000_0000_0010,
    S_SAT   = 16'b0000_0000_0000_0100,
    S_RDIFF = 16'b0000_0000_0000_1000,
    S_REL   = 16'b0000_0000_0001_0000,
    S_WREL  = 16'b0000_0000_0010_0000,
    S_RFIN  = 16'b0000_0000_0100_0000,
    S_WALK  = 16'b0000_0000_1000_0000,
    S_WCMP  = 16'b0000_0001_0000_0000,
    S_ERR0  = 16'b0000_0010_0000_0000,
    S_ERR1  = 16'b0000_0100_0000_0000,
    S_WERR  = 16'b0000_1000_0000_0000,
    S_MUL   = 16'b0001_0000_0000_0000,
    S_SUM   = 16'b0010_0000_0000_0000,
    S_WS    = 16'b0100_0000_0000_0000,
    S_DONE  = 16'b1000_0000_0000_0000
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] interval_q;
  logic [14:0] cruise_q;
  logic [7:0]  ramp_q;
  logic [8:0]  gain_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= prrn_pkg::INTERVAL_RST;
      cruise_q   <= prrn_pkg::CRUISE_RST;
      ramp_q     <= prrn_pkg::RAMP_RST;
      gain_q     <= prrn_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (prrn_pkg::reg_idx_e'(paddr[3:2]))
        prrn_pkg::REG_INTERVAL: interval_q <= pwdata[15:0];
        prrn_pkg::REG_CRUISE:   cruise_q   <= pwdata[14:0];
        prrn_pkg::REG_RAMP:     ramp_q     <= pwdata[7:0];
        prrn_pkg::REG_GAIN:     gain_q     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (prrn_pkg::reg_idx_e'(paddr[3:2]))
      prrn_pkg::REG_INTERVAL: prdata = {16'd0, interval_q};
      prrn_pkg::REG_CRUISE:   prdata = {17'd0, cruise_q};
      prrn_pkg::REG_RAMP:     prdata = {24'd0, ramp_q};
      prrn_pkg::REG_GAIN:     prdata = {23'd0, gain_q};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // navigator state
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  prrn_pkg::mode_e       mode_q, mode_d;
  prrn_pkg::status_e     status_q, status_d;
  logic [CW-1:0]         stored_q, stored_d;
  logic [CW-1:0]         rp_q, rp_d;
  logic signed [31:0]    trav_q, trav_d;
  logic signed [31:0]    mark_q, mark_d;
  logic signed [15:0]    start_q, start_d;
  logic signed [23:0]    smooth_q, smooth_d;
  logic [15:0]           speed_q, speed_d;
  logic signed [15:0]    dhead_q, dhead_d;
  logic                  due_q, due_d;
  prrn_pkg::acc_t        acc_q, acc_d;
  logic signed [33:0]    prod_q, prod_d;

  // latched item
  logic [1:0]            cmd_q;
  logic signed [15:0]    step_q;
  logic signed [15:0]    hd_q;

  // output register
  logic                  res_valid_q, res_valid_d;
  logic                  out_load;
  logic [15:0]           res_speed_q;
  logic signed [15:0]    res_head_q;
  logic [1:0]            res_mode_q;
  logic [CW-1:0]         res_cnt_q;
  logic [2:0]            res_stat_q;

  // waypoint memory: {distance, relative heading}
  logic [47:0]           mem_q [MAX_POINTS];
  logic [47:0]           rd_q;
  logic                  rd_en, wr_en;
  logic signed [31:0]    rd_dist;
  logic signed [15:0]    rd_head;

  logic                  item_acc;

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign rd_dist      = $signed(rd_q[47:16]);
  assign rd_head      = $signed(rd_q[15:0]);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rp_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[stored_q[AW-1:0]] <= {trav_q, acc_q[15:0]};
    end
  end

  // ---------------------------------------------------------------------------
  // shared add/sub unit; every distance, angle and filter sum, difference and wrap step goes through it
  // ---------------------------------------------------------------------------
  prrn_pkg::acc_t alu_a, alu_b, alu_res;
  logic           alu_sub;
  logic [8:0]     gain_eff;
  logic           rel_in, err_in, smooth_in;

  assign rel_in    = (acc_q <= prrn_pkg::DEG180) && (acc_q >= prrn_pkg::NEG_DEG180);
  assign err_in    = (acc_q <= prrn_pkg::ERR_HALF) && (acc_q >= prrn_pkg::NEG_ERR_HALF);
  assign smooth_in = (acc_q <= prrn_pkg::SMOOTH_MAX) && (acc_q >= prrn_pkg::SMOOTH_MIN);
  assign gain_eff  = (gain_q > prrn_pkg::GAIN_ONE) ? prrn_pkg::GAIN_ONE : gain_q;

  always_comb begin
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_SAT: begin
        alu_a = {{2{trav_q[31]}}, trav_q};
        alu_b = {{18{step_q[15]}}, step_q};
      end
      S_RDIFF: begin
        alu_a   = {{2{trav_q[31]}}, trav_q};
        alu_b   = {{2{mark_q[31]}}, mark_q};
        alu_sub = 1'b1;
      end
      S_REL: begin
        alu_a   = {{18{hd_q[15]}}, hd_q};
        alu_b   = {{18{start_q[15]}}, start_q};
        alu_sub = 1'b1;
      end
      S_WREL: begin
        alu_b   = prrn_pkg::DEG360;
        alu_sub = (acc_q > prrn_pkg::DEG180);
      end
      S_ERR0: begin
        alu_a = {{18{rd_head[15]}}, rd_head};
        alu_b = {{18{start_q[15]}}, start_q};
      end
      S_ERR1: begin
        // target heading scaled into the filter format, minus the filter state
        alu_a   = acc_q <<< 8;
        alu_b   = {{10{smooth_q[23]}}, smooth_q};
        alu_sub = 1'b1;
      end
      S_WERR: begin
        alu_b   = prrn_pkg::ERR_FULL;
        alu_sub = (acc_q > prrn_pkg::ERR_HALF);
      end
      S_SUM: begin
        // floor division by 256 is the arithmetic shift of the product
        alu_a = {{10{smooth_q[23]}}, smooth_q};
        alu_b = {{8{prod_q[33]}}, prod_q[33:8]};
      end
      S_WS: begin
        alu_b   = prrn_pkg::ERR_FULL;
        alu_sub = (acc_q > prrn_pkg::SMOOTH_MAX);
      end
      default: ;
    endcase
    alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic [31:0]     trav_sat;
  prrn_pkg::acc_t  intv_ext;
  prrn_pkg::mode_e cmd_target;

  assign intv_ext = {18'd0, interval_q};

  // saturate the travelled distance at the signed 32-bit limits
  always_comb begin
    if (alu_res > prrn_pkg::SAT_MAX) begin
      trav_sat = prrn_pkg::SAT_MAX[31:0];
    end else if (alu_res < prrn_pkg::SAT_MIN) begin
      trav_sat = prrn_pkg::SAT_MIN[31:0];
    end else begin
      trav_sat = alu_res[31:0];
    end
  end

  always_comb begin
    unique case (prrn_pkg::cmd_e'(cmd_q))
      prrn_pkg::CMD_REC:  cmd_target = prrn_pkg::MODE_REC;
      prrn_pkg::CMD_PLAY: cmd_target = prrn_pkg::MODE_PLAY;
      default:            cmd_target = prrn_pkg::MODE_IDLE;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    status_d = status_q;
    stored_d = stored_q;
    rp_d     = rp_q;
    trav_d   = trav_q;
    mark_d   = mark_q;
    start_d  = start_q;
    smooth_d = smooth_q;
    speed_d  = speed_q;
    dhead_d  = dhead_q;
    due_d    = due_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          status_d = prrn_pkg::STAT_OK;
          if (prrn_pkg::cmd_e'(item_i.cmd) != prrn_pkg::CMD_TICK) begin
            state_d = S_CMD;
          end else if (mode_q == prrn_pkg::MODE_IDLE) begin
            // idle tick changes nothing
            state_d = S_DONE;
          end else begin
            state_d = S_SAT;
          end
        end
      end

      S_CMD: begin
        state_d = S_DONE;
        // a command naming the current mode is a no-op
        if (cmd_target != mode_q) begin
          unique case (cmd_target)
            prrn_pkg::MODE_REC: begin
              stored_d = '0;
              trav_d   = '0;
              mark_d   = '0;
              start_d  = hd_q;
              mode_d   = prrn_pkg::MODE_REC;
            end
            prrn_pkg::MODE_PLAY: begin
              if (stored_q == '0) begin
                status_d = prrn_pkg::STAT_REFUSED;
              end else begin
                rp_d     = '0;
                trav_d   = '0;
                speed_d  = '0;
                start_d  = hd_q;
                smooth_d = {hd_q, 8'd0};
                mode_d   = prrn_pkg::MODE_PLAY;
              end
            end
            default: mode_d = prrn_pkg::MODE_IDLE;
          endcase
        end
      end

      S_SAT: begin
        trav_d  = trav_sat;
        state_d = (mode_q == prrn_pkg::MODE_REC) ? S_RDIFF : S_WALK;
      end

      // recording: |travelled - last mark| against the interval
      S_RDIFF: begin
        due_d   = (alu_res >= intv_ext) || (alu_res <= -intv_ext);
        state_d = S_REL;
      end

      S_REL: begin
        acc_d   = alu_res;
        state_d = S_WREL;
      end

      // one 360 degree step per cycle until the heading is within +-180
      S_WREL: begin
        if (rel_in) begin
          state_d = S_RFIN;
        end else begin
          acc_d = alu_res;
        end
      end

      S_RFIN: begin
        state_d = S_DONE;
        if (due_q) begin
          if (stored_q < MAX_CNT) begin
            wr_en    = 1'b1;
            stored_d = stored_q + 1'b1;
            mark_d   = trav_q;
            status_d = prrn_pkg::STAT_STORED;
          end else begin
            mode_d   = prrn_pkg::MODE_IDLE;
            status_d = prrn_pkg::STAT_FULL;
          end
        end
      end

      // playback: fetch the waypoint at the replay position
      S_WALK: begin
        if (rp_q < stored_q) begin
          rd_en   = 1'b1;
          state_d = S_WCMP;
        end else begin
          // nothing left ahead: arrived
          speed_d  = '0;
          dhead_d  = hd_q;
          mode_d   = prrn_pkg::MODE_IDLE;
          status_d = prrn_pkg::STAT_ARRIVED;
          state_d  = S_DONE;
        end
      end

      // skip waypoints already reached
      S_WCMP: begin
        if (trav_q >= rd_dist) begin
          rp_d    = rp_q + 1'b1;
          state_d = S_WALK;
        end else begin
          state_d = S_ERR0;
        end
      end

      S_ERR0: begin
        acc_d   = alu_res;
        state_d = S_ERR1;
      end

      S_ERR1: begin
        acc_d   = alu_res;
        state_d = S_WERR;
      end

      // shortest-way heading error
      S_WERR: begin
        if (err_in) begin
          state_d = S_MUL;
        end else begin
          acc_d = alu_res;
        end
      end

      S_MUL: begin
        prod_d  = $signed(acc_q[23:0]) * $signed({1'b0, gain_eff});
        state_d = S_SUM;
      end

      S_SUM: begin
        acc_d   = alu_res;
        state_d = S_WS;
      end

      // keep the filter state in 24 signed bits, then commit
      S_WS: begin
        if (smooth_in) begin
          smooth_d = acc_q[23:0];
          dhead_d  = acc_q[23:8];
          if (speed_q < {1'b0, cruise_q}) begin
            speed_d = speed_q + {8'd0, ramp_q};
          end else begin
            speed_d = {1'b0, cruise_q};
          end
          state_d = S_DONE;
        end else begin
          acc_d = alu_res;
        end
      end

      // hand over to the output register once it is free
      S_DONE: begin
        if (!res_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= prrn_pkg::MODE_IDLE;
      status_q    <= prrn_pkg::STAT_OK;
      stored_q    <= '0;
      rp_q        <= '0;
      trav_q      <= '0;
      mark_q      <= '0;
      start_q     <= '0;
      smooth_q    <= '0;
      speed_q     <= '0;
      dhead_q     <= '0;
      due_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      status_q    <= status_d;
      stored_q    <= stored_d;
      rp_q        <= rp_d;
      trav_q      <= trav_d;
      mark_q      <= mark_d;
      start_q     <= start_d;
      smooth_q    <= smooth_d;
      speed_q     <= speed_d;
      dhead_q     <= dhead_d;
      due_q       <= due_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath and payload registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    if (item_acc) begin
      cmd_q  <= item_i.cmd;
      step_q <= item_i.distance_step;
      hd_q   <= item_i.heading;
    end
    if (out_load) begin
      res_speed_q <= speed_q;
      res_head_q  <= dhead_q;
      res_mode_q  <= mode_q;
      res_cnt_q   <= stored_q;
      res_stat_q  <= status_q;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.speed_out   = res_speed_q;
  assign result_o.heading_out = res_head_q;
  assign result_o.mode        = res_mode_q;
  assign result_o.point_count = res_cnt_q;
  assign result_o.status      = res_stat_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= MAX_CNT)
    else $error("stored waypoint count beyond capacity");

  a_replay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == prrn_pkg::MODE_PLAY) |-> (rp_q <= stored_q))
    else $error("replay position past stored waypoints");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> (state_q != S_IDLE))
    else $error("accepted beat not processed");

  a_speed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= prrn_pkg::SPEED_MAX)
    else $error("drive speed above ramp limit");
`endif

endmodule
